// ===== hw/rtl/crm_pkg.sv =====
// ----------------------------------------------------------------------------
// crm_pkg
// Types and constants of the cleaning robot motion controller.
// ----------------------------------------------------------------------------
package crm_pkg;

  localparam int unsigned CfgWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned TickWidth = 8;

  typedef enum logic [2:0] {
    MODE_MOVING  = 3'd0,
    MODE_TURNING = 3'd1,
    MODE_BACKING = 3'd2,
    MODE_DUST    = 3'd3,
    MODE_PAUSE   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    MOT_FORWARD  = 3'd0,
    MOT_LEFT     = 3'd1,
    MOT_RIGHT    = 3'd2,
    MOT_BACKWARD = 3'd3,
    MOT_STOP     = 3'd4
  } motor_t;

  typedef enum logic [1:0] {
    VAC_OFF    = 2'd0,
    VAC_NORMAL = 2'd1,
    VAC_BOOST  = 2'd2
  } vacuum_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DUST_CLEAN_TICKS = 2'd0,
    REG_BACKUP_TICKS     = 2'd1,
    REG_TURN_DONE_TICKS  = 2'd2,
    REG_PAUSE_TICKS      = 2'd3
  } cfg_idx_t;

  localparam logic [CfgWidth-1:0] DustCleanTicksRst = 8'd5;
  localparam logic [CfgWidth-1:0] BackupTicksRst    = 8'd3;
  localparam logic [CfgWidth-1:0] TurnDoneTicksRst  = 8'd2;
  localparam logic [CfgWidth-1:0] PauseTicksRst     = 8'd3;

  localparam logic [TickWidth-1:0] TickMax = '1;

endpackage

// ===== hw/rtl/crm_in_if.sv =====
// ----------------------------------------------------------------------------
// crm_in_if
// Sensor flag channel: one transaction per control tick.
// ----------------------------------------------------------------------------
interface crm_in_if;
  logic valid;
  logic ready;
  logic front_blocked;
  logic left_blocked;
  logic right_blocked;
  logic dust_present;

  modport source (
    output valid, front_blocked, left_blocked, right_blocked, dust_present,
    input  ready
  );

  modport sink (
    input  valid, front_blocked, left_blocked, right_blocked, dust_present,
    output ready
  );
endinterface

// ===== hw/rtl/crm_out_if.sv =====
// ----------------------------------------------------------------------------
// crm_out_if
// Command channel: motor and vacuum commands and the mode after the tick.
// ----------------------------------------------------------------------------
interface crm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] motor_command;
  logic [1:0] vacuum_command;
  logic [2:0] mode_after;

  modport source (
    output valid, motor_command, vacuum_command, mode_after,
    input  ready
  );

  modport sink (
    input  valid, motor_command, vacuum_command, mode_after,
    output ready
  );
endinterface

// ===== hw/rtl/cleaning_robot_motion_fsm.sv =====
// An accepted tick's command transaction is offered from the command register in the next cycle.
// Throughput: 1 tick per cycle while the command channel is ready; the command register frees as it is taken.
// The mode update and its commands settle in one pass of logic ahead of
// the command register.
// Reset (synchronous, rst_n low): mode moving, counters 0, motor forward,
// vacuum normal, registers at their defaults, no command pending.
// ----------------------------------------------------------------------------
// cleaning_robot_motion_fsm
// Five-mode motion and vacuum controller, one sensor tick per transaction.
// ----------------------------------------------------------------------------
module cleaning_robot_motion_fsm (
  input  logic                           clk,
  input  logic                           rst_n,
  crm_in_if.sink                         in_ch,
  crm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [crm_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [crm_pkg::CfgWidth-1:0]   cfg_data
);

  logic [crm_pkg::CfgWidth-1:0] dust_clean_ticks_r;
  logic [crm_pkg::CfgWidth-1:0] backup_ticks_r;
  logic [crm_pkg::CfgWidth-1:0] turn_done_ticks_r;
  logic [crm_pkg::CfgWidth-1:0] pause_ticks_r;

  crm_pkg::mode_t                mode_r, mode_nxt;
  logic [crm_pkg::TickWidth-1:0] ticks_r, ticks_nxt;
  logic [crm_pkg::CfgWidth-1:0]  dust_cnt_r, dust_cnt_nxt;
  logic [crm_pkg::CfgWidth-1:0]  backup_cnt_r, backup_cnt_nxt;
  crm_pkg::motor_t               motor_r, motor_nxt;
  crm_pkg::vacuum_t              vacuum_r, vacuum_nxt;

  logic       out_valid_r;
  logic [2:0] out_motor_r;
  logic [1:0] out_vacuum_r;
  logic [2:0] out_mode_r;

  logic                          accept;
  logic [crm_pkg::TickWidth-1:0] ticks_inc;
  logic [crm_pkg::CfgWidth-1:0]  dust_dec;
  logic [crm_pkg::CfgWidth-1:0]  backup_dec;
  logic                          boxed_in;
  logic                          sides_blocked;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ticks_inc  = (ticks_r == crm_pkg::TickMax) ? ticks_r
                                                     : ticks_r + 1'b1;
  assign dust_dec   = (dust_cnt_r != '0) ? dust_cnt_r - 1'b1 : dust_cnt_r;
  assign backup_dec = (backup_cnt_r != '0) ? backup_cnt_r - 1'b1 : backup_cnt_r;
  assign sides_blocked = in_ch.left_blocked && in_ch.right_blocked;
  assign boxed_in      = sides_blocked && in_ch.front_blocked;

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      crm_pkg::MODE_MOVING: begin
        if (in_ch.dust_present) begin
          mode_nxt = crm_pkg::MODE_DUST;
        end else if (in_ch.front_blocked) begin
          mode_nxt = crm_pkg::MODE_TURNING;
        end
      end
      crm_pkg::MODE_TURNING: begin
        if (boxed_in) begin
          mode_nxt = crm_pkg::MODE_BACKING;
        end else if (sides_blocked) begin
          mode_nxt = crm_pkg::MODE_PAUSE;
        end else if (ticks_inc >= turn_done_ticks_r) begin
          mode_nxt = crm_pkg::MODE_MOVING;
        end
      end
      crm_pkg::MODE_BACKING: begin
        if (backup_dec == '0) begin
          mode_nxt = crm_pkg::MODE_TURNING;
        end
      end
      crm_pkg::MODE_DUST: begin
        if (dust_dec == '0) begin
          mode_nxt = crm_pkg::MODE_MOVING;
        end
      end
      crm_pkg::MODE_PAUSE: begin
        if (ticks_inc >= pause_ticks_r) begin
          mode_nxt = crm_pkg::MODE_BACKING;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  // commands and counters
  always_comb begin
    motor_nxt      = motor_r;
    vacuum_nxt     = vacuum_r;
    dust_cnt_nxt   = dust_cnt_r;
    backup_cnt_nxt = backup_cnt_r;
    case (mode_r)
      crm_pkg::MODE_MOVING: begin
        motor_nxt  = crm_pkg::MOT_FORWARD;
        vacuum_nxt = crm_pkg::VAC_NORMAL;
        if (in_ch.dust_present) begin
          dust_cnt_nxt = dust_clean_ticks_r;
        end
      end
      crm_pkg::MODE_TURNING: begin
        vacuum_nxt = crm_pkg::VAC_NORMAL;
        if (boxed_in) begin
          backup_cnt_nxt = backup_ticks_r;
        end else if (!sides_blocked) begin
          motor_nxt = in_ch.left_blocked ? crm_pkg::MOT_RIGHT : crm_pkg::MOT_LEFT;
        end
      end
      crm_pkg::MODE_BACKING: begin
        motor_nxt      = crm_pkg::MOT_BACKWARD;
        vacuum_nxt     = crm_pkg::VAC_NORMAL;
        backup_cnt_nxt = backup_dec;
      end
      crm_pkg::MODE_DUST: begin
        motor_nxt    = crm_pkg::MOT_STOP;
        vacuum_nxt   = crm_pkg::VAC_BOOST;
        dust_cnt_nxt = dust_dec;
      end
      crm_pkg::MODE_PAUSE: begin
        motor_nxt  = crm_pkg::MOT_STOP;
        vacuum_nxt = crm_pkg::VAC_NORMAL;
        if (ticks_inc >= pause_ticks_r) begin
          backup_cnt_nxt = backup_ticks_r;
        end
      end
      default: begin
        motor_nxt = motor_r;
      end
    endcase
    ticks_nxt = (mode_nxt != mode_r) ? '0 : ticks_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dust_clean_ticks_r <= crm_pkg::DustCleanTicksRst;
      backup_ticks_r     <= crm_pkg::BackupTicksRst;
      turn_done_ticks_r  <= crm_pkg::TurnDoneTicksRst;
      pause_ticks_r      <= crm_pkg::PauseTicksRst;
    end else if (cfg_we) begin
      case (crm_pkg::cfg_idx_t'(cfg_index))
        crm_pkg::REG_DUST_CLEAN_TICKS: dust_clean_ticks_r <= cfg_data;
        crm_pkg::REG_BACKUP_TICKS:     backup_ticks_r     <= cfg_data;
        crm_pkg::REG_TURN_DONE_TICKS:  turn_done_ticks_r  <= cfg_data;
        crm_pkg::REG_PAUSE_TICKS:      pause_ticks_r      <= cfg_data;
        default: begin
          dust_clean_ticks_r <= dust_clean_ticks_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= crm_pkg::MODE_MOVING;
      ticks_r      <= '0;
      dust_cnt_r   <= '0;
      backup_cnt_r <= '0;
      motor_r      <= crm_pkg::MOT_FORWARD;
      vacuum_r     <= crm_pkg::VAC_NORMAL;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      ticks_r      <= ticks_nxt;
      dust_cnt_r   <= dust_cnt_nxt;
      backup_cnt_r <= backup_cnt_nxt;
      motor_r      <= motor_nxt;
      vacuum_r     <= vacuum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_motor_r  <= motor_nxt;
      out_vacuum_r <= vacuum_nxt;
      out_mode_r   <= mode_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.motor_command  = out_motor_r;
  assign out_ch.vacuum_command = out_vacuum_r;
  assign out_ch.mode_after     = out_mode_r;

endmodule
